@@ rtl/core/sphere_pair_collision_detect_assert.svh @@
// Assertion macros for the sphere pair collision detector.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SPHERE_PAIR_COLLISION_DETECT_ASSERT_SVH
`define SPHERE_PAIR_COLLISION_DETECT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sphc assertion failed");

// Next-cycle implication, disabled while in reset.
`define SPHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sphc assertion failed");

`endif

@@ rtl/core/sphc_pkg.sv @@
// Shared types and constants of the sphere pair collision detector.
// No dependencies; imported by sphere_pair_collision_detect.
package sphc_pkg;

	localparam int CW       = 24;  // coordinate width, signed Q12.12
	localparam int RADIUS_W = 23;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int SEP_W    = 23;
	localparam int OVL_W    = 24;
	localparam int DIR_W    = 16;
	localparam int FRAC_W   = 14;  // direction fraction bits
	localparam int Q_W      = FRAC_W + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic CFG_COUNT  = 1'b0;
	localparam logic CFG_MINSEP = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RST  = 7'd64;
	localparam logic [SEP_W-1:0] MINSEP_RST = 23'd4;

	typedef struct packed {
		logic                       opcode;
		logic [IDX_W-1:0]           index;
		logic signed [CW-1:0]       pos_x;
		logic signed [CW-1:0]       pos_y;
		logic signed [CW-1:0]       pos_z;
		logic [RADIUS_W-1:0]        radius_in;
	} req_t;

	typedef struct packed {
		logic                       hit;
		logic [IDX_W-1:0]           first_index;
		logic [IDX_W-1:0]           second_index;
		logic [OVL_W-1:0]           overlap;
		logic signed [DIR_W-1:0]    dir_x;
		logic signed [DIR_W-1:0]    dir_y;
		logic signed [DIR_W-1:0]    dir_z;
		logic                       last;
	} rsp_t;

	typedef struct packed {
		logic [CW-1:0]       x;
		logic [CW-1:0]       y;
		logic [CW-1:0]       z;
		logic [RADIUS_W-1:0] r;
	} entry_t;

endpackage

@@ rtl/core/sphere_pair_collision_detect.sv @@
// Sphere pair collision detector: particle table in one synchronous memory,
// query walks entries j > i through a bit-serial square root and divider.
//
// Channels: req (valid/ready) carries write or query items; rsp (valid/ready)
// carries results; cfg (valid/ready, always ready) writes particle_count and
// min_separation, index 0 and 1.
// A write item gives no result.
// A query of entry i gives one result per hit in rising j, then a terminator
// with last set. Each checked entry passes through read, difference, squares
// and sum, then the square root (one result bit a cycle) and the compare. A
// hit adds the divider (three lanes side by side) and the hand-off of the
// result. A query also reads entry i first and sends the terminator last.
// req is ready only between items. The result register frees the engine once
// it has taken a result; while a held result is stalled on rsp, the engine
// holds in its hand-off state.
// Reset clears control and resets the config registers; table entries are undefined
// until written and must be written before a query reads them.
`include "sphere_pair_collision_detect_assert.svh"

module sphere_pair_collision_detect
	import sphc_pkg::*;
#(
	parameter int MAX_PARTICLES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [SEP_W-1:0]     cfg_data
);

	localparam int AW   = $clog2(MAX_PARTICLES);
	localparam int SW   = 2 * CW + 2;   // sum of three squares
	localparam int RW   = CW + 1;       // root width
	localparam int SQ_N = SW / 2;       // square root iterations
	localparam int CTW  = 5;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDI   = 4'd1;
	localparam logic [3:0] S_LOADI = 4'd2;
	localparam logic [3:0] S_RDJ   = 4'd3;
	localparam logic [3:0] S_LOADJ = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_SUM   = 4'd6;
	localparam logic [3:0] S_SQRT  = 4'd7;
	localparam logic [3:0] S_CHECK = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_EMIT  = 4'd10;
	localparam logic [3:0] S_TERM  = 4'd11;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [SEP_W-1:0]      minsep_q;
	logic [IDX_W-1:0]      i_q;
	logic [CNT_W-1:0]      j_q;
	logic [CTW-1:0]        cnt_q;

	entry_t                mem [MAX_PARTICLES];
	entry_t                rd_q;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;

	logic [CW-1:0]         ci_q [3];
	logic [RADIUS_W-1:0]   ri_q;
	logic [CW-1:0]         cj [3];

	logic [CW:0]           mag_s1 [3];
	logic                  neg_s1 [3];
	logic [OVL_W-1:0]      rsum_s1;
	logic [2*CW+1:0]       sq_s2 [3];

	logic [SW-1:0]         rad_q;
	logic [RW-1:0]         root_q;
	logic [RW+2:0]         srem_q;
	logic [RW+2:0]         s_sh;
	logic [RW+2:0]         s_tr;

	logic [CW+1:0]         drem_q [3];
	logic [Q_W-1:0]        nl_q [3];
	logic [Q_W-1:0]        quo_q [3];
	logic [CW+1:0]         d_sh [3];

	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [CNT_W-1:0]      count_eff;
	logic [CNT_W-1:0]      j_inc;
	logic                  more_j;
	logic                  query_ok;
	logic                  hit_now;
	logic                  out_free;
	logic                  emit_go;
	logic signed [DIR_W-1:0] dir_v [3];

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign count_eff = (count_q > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : count_q;
	assign j_inc     = j_q + CNT_W'(1);
	assign more_j    = (j_inc < count_eff);
	assign query_ok  = ({1'b0, req.index} < CNT_W'(MAX_PARTICLES))
		&& (({1'b0, req.index} + CNT_W'(1)) < count_eff);
	assign hit_now   = ({2'b0, minsep_q} < root_q) && (root_q < {1'b0, rsum_s1});
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign emit_go   = ((state_q == S_EMIT) || (state_q == S_TERM)) && out_free;
	assign wr_en     = req_valid && req_ready && (req.opcode == OP_WRITE)
		&& ({1'b0, req.index} < CNT_W'(MAX_PARTICLES));
	assign rd_addr   = (state_q == S_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];

	assign cj[0] = rd_q.x;
	assign cj[1] = rd_q.y;
	assign cj[2] = rd_q.z;

	assign s_sh = {srem_q[RW:0], rad_q[SW-1:SW-2]};
	assign s_tr = {1'b0, root_q, 2'b01};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_sh[k]  = {drem_q[k][CW:0], nl_q[k][Q_W-1]};
			dir_v[k] = neg_s1[k] ? -$signed({1'b0, quo_q[k]}) : $signed({1'b0, quo_q[k]});
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[req.index[AW-1:0]] <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z,
				r: req.radius_in};
		end
		rd_q <= mem[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOADI: begin
				for (int k = 0; k < 3; k++) ci_q[k] <= cj[k];
				ri_q <= rd_q.r;
			end
			S_LOADJ: begin
				for (int k = 0; k < 3; k++) begin
					logic [CW:0] d;
					d = {cj[k][CW-1], cj[k]} - {ci_q[k][CW-1], ci_q[k]};
					neg_s1[k] <= d[CW];
					mag_s1[k] <= d[CW] ? (~d + (CW+1)'(1)) : d;
				end
				rsum_s1 <= {1'b0, ri_q} + {1'b0, rd_q.r};
			end
			S_MUL: begin
				for (int k = 0; k < 3; k++) sq_s2[k] <= mag_s1[k] * mag_s1[k];
			end
			S_SUM: begin
				rad_q  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
				root_q <= '0;
				srem_q <= '0;
			end
			S_SQRT: begin
				// take two radicand bits, try root*4+1
				rad_q <= {rad_q[SW-3:0], 2'b00};
				if (s_sh >= s_tr) begin
					srem_q <= s_sh - s_tr;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					srem_q <= s_sh;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			S_CHECK: begin
				// quotient fits Q_W bits since |d| <= distance
				for (int k = 0; k < 3; k++) begin
					drem_q[k] <= {2'b00, mag_s1[k][CW:1]};
					nl_q[k]   <= {mag_s1[k][0], {FRAC_W{1'b0}}};
					quo_q[k]  <= '0;
				end
			end
			S_DIV: begin
				for (int k = 0; k < 3; k++) begin
					nl_q[k] <= {nl_q[k][Q_W-2:0], 1'b0};
					if (d_sh[k] >= {1'b0, root_q}) begin
						drem_q[k] <= d_sh[k] - {1'b0, root_q};
						quo_q[k]  <= {quo_q[k][Q_W-2:0], 1'b1};
					end else begin
						drem_q[k] <= d_sh[k];
						quo_q[k]  <= {quo_q[k][Q_W-2:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			rsp_q.hit          <= 1'b1;
			rsp_q.first_index  <= i_q;
			rsp_q.second_index <= j_q[IDX_W-1:0];
			rsp_q.overlap      <= rsum_s1 - root_q[OVL_W-1:0];
			rsp_q.dir_x        <= dir_v[0];
			rsp_q.dir_y        <= dir_v[1];
			rsp_q.dir_z        <= dir_v[2];
			rsp_q.last         <= 1'b0;
		end else if (state_q == S_TERM && out_free) begin
			rsp_q <= '{hit: 1'b0, first_index: i_q, second_index: '0, overlap: '0,
				dir_x: '0, dir_y: '0, dir_z: '0, last: 1'b1};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= COUNT_RST;
			minsep_q    <= MINSEP_RST;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COUNT:  count_q  <= cfg_data[CNT_W-1:0];
					CFG_MINSEP: minsep_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (emit_go) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req_valid && req.opcode == OP_QUERY) begin
						i_q     <= req.index;
						state_q <= query_ok ? S_RDI : S_TERM;
					end
				end
				S_RDI: state_q <= S_LOADI;
				S_LOADI: begin
					j_q     <= {1'b0, i_q} + CNT_W'(1);
					state_q <= S_RDJ;
				end
				S_RDJ:   state_q <= S_LOADJ;
				S_LOADJ: state_q <= S_MUL;
				S_MUL:   state_q <= S_SUM;
				S_SUM: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + CTW'(1);
					if (cnt_q == CTW'(SQ_N - 1)) state_q <= S_CHECK;
				end
				S_CHECK: begin
					cnt_q <= '0;
					if (hit_now) begin
						state_q <= S_DIV;
					end else if (more_j) begin
						j_q     <= j_inc;
						state_q <= S_RDJ;
					end else begin
						state_q <= S_TERM;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CTW'(1);
					if (cnt_q == CTW'(Q_W - 1)) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (more_j) begin
							j_q     <= j_inc;
							state_q <= S_RDJ;
						end else begin
							state_q <= S_TERM;
						end
					end
				end
				S_TERM: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SPHC_ASSERT_NOW(a_hit_order, clk, arst_n, rsp_valid && rsp.hit, rsp.second_index > rsp.first_index)
	`SPHC_ASSERT_NOW(a_hit_overlap, clk, arst_n, rsp_valid && rsp.hit, rsp.overlap != '0 && !rsp.last)
	`SPHC_ASSERT_NEXT(a_query_busy, clk, arst_n, req_valid && req_ready && req.opcode == OP_QUERY, !req_ready)
	`SPHC_ASSERT_NOW(a_sqrt_count, clk, arst_n, state_q == S_SQRT, cnt_q < CTW'(SQ_N))

endmodule

@@ verif/sphere_pair_collision_detect_test.sv @@
// Self-checking bench for sphere_pair_collision_detect: fills the particle table,
// runs directed and random write/query items, and checks each result item.
// Depends on sphc_pkg and the RTL of the block only.
module sphere_pair_collision_detect_test;
	import sphc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 64;
	localparam longint CYCLE_LIMIT = 6000000;

	class pair_scoreboard;
		logic signed [CW-1:0] px[TABLE_DEPTH];
		logic signed [CW-1:0] py[TABLE_DEPTH];
		logic signed [CW-1:0] pz[TABLE_DEPTH];
		logic [RADIUS_W-1:0] pr[TABLE_DEPTH];
		logic [CNT_W-1:0] count_reg;
		logic [SEP_W-1:0] minsep_reg;
		rsp_t pending[$];
		int errors;
		int queries;
		int hits;
		int checked;

		function new();
			count_reg = COUNT_RST;
			minsep_reg = MINSEP_RST;
			errors = 0;
			queries = 0;
			hits = 0;
			checked = 0;
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		function void set_register(logic idx, logic [SEP_W-1:0] data);
			if (idx == CFG_COUNT)
				count_reg = data[CNT_W-1:0];
			else
				minsep_reg = data;
		endfunction

		function automatic logic [63:0] floor_root(logic [127:0] s);
			logic [63:0] r;
			logic [63:0] c;
			r = 0;
			for (int b = 34; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if ({64'd0, c} * {64'd0, c} <= s)
					r = c;
			end
			return r;
		endfunction

		function automatic logic [DIR_W-1:0] direction(longint d, logic [63:0] span);
			logic [63:0] m;
			logic [63:0] q;
			m = (d < 0) ? -d : d;
			q = (m << FRAC_W) / span;
			if (d < 0)
				q = -q;
			return q[DIR_W-1:0];
		endfunction

		function void note_request(req_t r);
			int lim;
			longint dx, dy, dz;
			logic [127:0] s;
			logic [63:0] span, rsum;
			rsp_t o;
			if (r.opcode == OP_WRITE) begin
				px[r.index] = r.pos_x;
				py[r.index] = r.pos_y;
				pz[r.index] = r.pos_z;
				pr[r.index] = r.radius_in;
				return;
			end
			queries++;
			lim = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
			for (int j = r.index + 1; j < lim; j++) begin
				dx = longint'(px[j]) - longint'(px[r.index]);
				dy = longint'(py[j]) - longint'(py[r.index]);
				dz = longint'(pz[j]) - longint'(pz[r.index]);
				s = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
				span = floor_root(s);
				rsum = 64'(pr[r.index]) + 64'(pr[j]);
				if (span > minsep_reg && span < rsum) begin
					o = '0;
					o.hit = 1'b1;
					o.first_index = r.index;
					o.second_index = j[IDX_W-1:0];
					o.overlap = OVL_W'(rsum - span);
					o.dir_x = direction(dx, span);
					o.dir_y = direction(dy, span);
					o.dir_z = direction(dz, span);
					pending = {pending, o};
					hits++;
				end
			end
			o = '0;
			o.first_index = r.index;
			o.last = 1'b1;
			pending = {pending, o};
		endfunction

		task check_result(rsp_t got);
			rsp_t w;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result item %p", got));
				return;
			end
			w = pending.pop_front();
			if (got.hit != w.hit) report($sformatf("hit %0d want %0d", got.hit, w.hit));
			if (got.first_index != w.first_index)
				report($sformatf("first_index %0d want %0d", got.first_index, w.first_index));
			if (got.second_index != w.second_index)
				report($sformatf("second_index %0d want %0d", got.second_index, w.second_index));
			if (got.overlap != w.overlap)
				report($sformatf("overlap %0d want %0d", got.overlap, w.overlap));
			if (got.dir_x != w.dir_x) report($sformatf("dir_x %0d want %0d", got.dir_x, w.dir_x));
			if (got.dir_y != w.dir_y) report($sformatf("dir_y %0d want %0d", got.dir_y, w.dir_y));
			if (got.dir_z != w.dir_z) report($sformatf("dir_z %0d want %0d", got.dir_z, w.dir_z));
			if (got.last != w.last) report($sformatf("last %0d want %0d", got.last, w.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_COUNT;
	logic [SEP_W-1:0] cfg_data = '0;

	pair_scoreboard sb = new();
	longint cycles = 0;
	bit calm = 1'b1;
	bit hold_off = 1'b0;
	event stall_go;
	int writes_sent = 0;
	logic signed [CW-1:0] center = '0;

	sphere_pair_collision_detect dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Hold the result side off for a long stretch when asked.
	always @(stall_go) begin
		hold_off <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Result side: take items, stall at random, honor a long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			if (hold_off)
				rsp_ready <= 1'b0;
			else
				rsp_ready <= calm || ($urandom_range(99) >= 12);
		end
	end

	task send_item(req_t r);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		if (!calm && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task write_register(logic idx, logic [SEP_W-1:0] data);
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_register(idx, data);
	endtask

	function automatic req_t particle(logic [IDX_W-1:0] idx, bit wild);
		req_t r;
		r.opcode = OP_WRITE;
		r.index = idx;
		if (wild) begin
			r.pos_x = CW'($urandom);
			r.pos_y = CW'($urandom);
			r.pos_z = CW'($urandom);
			r.radius_in = RADIUS_W'($urandom);
		end else begin
			// Cluster around a center so that pairs overlap.
			r.pos_x = center + CW'($signed($urandom_range(32768)) - 16384);
			r.pos_y = center + CW'($signed($urandom_range(32768)) - 16384);
			r.pos_z = center + CW'($signed($urandom_range(32768)) - 16384);
			r.radius_in = RADIUS_W'($urandom_range(16384, 4096));
		end
		return r;
	endfunction

	function automatic req_t query(logic [IDX_W-1:0] idx);
		req_t r;
		r = '0;
		r.opcode = OP_QUERY;
		r.index = idx;
		r.pos_x = CW'($urandom);
		r.radius_in = RADIUS_W'($urandom);
		return r;
	endfunction

	initial begin
		req_t r;
		int lim;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < TABLE_DEPTH; k++)
			send_item(particle(IDX_W'(k), k % 9 == 8));

		// Directed part.
		send_item(query(0));
		send_item(query(IDX_W'(TABLE_DEPTH - 1)));
		r = '0;
		r.pos_x = {1'b0, {(CW-1){1'b1}}};
		r.pos_y = {1'b0, {(CW-1){1'b1}}};
		r.pos_z = {1'b0, {(CW-1){1'b1}}};
		r.radius_in = '1;
		send_item(r);
		r.index = 1;
		r.pos_x = {1'b1, {(CW-1){1'b0}}};
		r.pos_y = {1'b1, {(CW-1){1'b0}}};
		r.pos_z = {1'b1, {(CW-1){1'b0}}};
		send_item(r);
		r.index = 2;
		r.pos_x = '0;
		r.pos_y = '0;
		r.pos_z = 100;
		r.radius_in = 0;
		send_item(r);
		r.index = 3;
		r.pos_z = 100;
		r.radius_in = 5000;
		send_item(r);
		r.index = 4;
		r.pos_z = 103;
		send_item(r);
		write_register(CFG_COUNT, 23'd5);
		send_item(query(0));
		send_item(query(1));
		send_item(query(3));
		write_register(CFG_MINSEP, 23'd0);
		send_item(query(3));
		send_item(query(2));
		write_register(CFG_COUNT, 23'd1);
		send_item(query(0));
		write_register(CFG_COUNT, {16'h7fff, 7'd127});
		write_register(CFG_MINSEP, '1);
		send_item(query(0));
		write_register(CFG_MINSEP, MINSEP_RST);
		send_item(query(0));

		// Random part in phases, each with its own register setting.
		calm = 1'b0;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_register(CFG_COUNT, 23'd64);
				1: write_register(CFG_COUNT, 23'd2);
				7: write_register(CFG_COUNT, 23'd127);
				default: write_register(CFG_COUNT,
					{16'($urandom_range(65535)), 7'(3 + $urandom_range(11))});
			endcase
			case (ph % 4)
				0: write_register(CFG_MINSEP, 23'd0);
				1: write_register(CFG_MINSEP, SEP_W'($urandom_range(4000)));
				2: write_register(CFG_MINSEP, 23'd4);
				default: write_register(CFG_MINSEP, SEP_W'($urandom_range(1000, 20)));
			endcase
			if (ph == 7)
				write_register(CFG_MINSEP, '1);
			lim = (sb.count_reg > TABLE_DEPTH) ? TABLE_DEPTH : sb.count_reg;
			center = CW'($urandom);
			if (ph == 3)
				-> stall_go;
			for (int n = 0; n < ((lim > 32) ? 20 : 60); n++) begin
				if ($urandom_range(99) < 55)
					send_item(particle(IDX_W'((lim < TABLE_DEPTH && $urandom_range(9) == 0) ?
						$urandom_range(TABLE_DEPTH - 1) : $urandom_range(lim - 1)),
						$urandom_range(9) == 0));
				else if ($urandom_range(9) == 0)
					send_item(query(IDX_W'($urandom_range(TABLE_DEPTH - 1))));
				else
					send_item(query(IDX_W'($urandom_range(lim - 1))));
			end
		end

		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d queries, %0d hit items, %0d result items checked",
			sb.queries, sb.hits, sb.checked);
		$display("register settings ranged over counts 1 to 127 and separations 0 to max");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ sphere_pair_collision_detect.f @@
+incdir+rtl/core
rtl/core/sphc_pkg.sv
rtl/core/sphere_pair_collision_detect.sv
verif/sphere_pair_collision_detect_test.sv
